// File: design/bpm_pkg.sv
package bpm_pkg;

	// table geometry and poll timing
	localparam int NUM_BREAKPOINTS = 256;
	localparam int POLL_INTERVAL   = 500;
	localparam int POLL_W          = 16;

	// payload widths
	localparam int ADDR_W = 32;
	localparam int LEN_W  = 8;
	localparam int BYTE_W = 8;

	// configuration port
	localparam int APB_ADDR_W = 2;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-1:0] REG_SINGLE_STEP = '0;

	// debugger write decode
	localparam logic [BYTE_W-1:0] INSERT_BYTE = 8'hcc;
	localparam logic [LEN_W-1:0]  ONE_BYTE    = 8'd1;

	// stop reasons
	localparam logic [1:0] REASON_NONE       = 2'd0;
	localparam logic [1:0] REASON_BREAKPOINT = 2'd1;
	localparam logic [1:0] REASON_TRACE      = 2'd2;
	localparam logic [1:0] REASON_USER       = 2'd3;

	// write actions
	localparam logic [1:0] ACT_INSERTED = 2'd0;
	localparam logic [1:0] ACT_FULL     = 2'd1;
	localparam logic [1:0] ACT_REMOVED  = 2'd2;
	localparam logic [1:0] ACT_FORWARD  = 2'd3;

	// operation carried by a wave through the cell row
	localparam logic [1:0] OP_CHECK   = 2'd0;
	localparam logic [1:0] OP_INSERT  = 2'd1;
	localparam logic [1:0] OP_REMOVE  = 2'd2;
	localparam logic [1:0] OP_FORWARD = 2'd3;

	typedef struct packed {
		logic              valid;
		logic [1:0]        op;
		logic [ADDR_W-1:0] addr;
		logic [1:0]        pre_reason;
		logic              hit;
	} wave_t;

endpackage

// File: design/bpm_cell.sv
module bpm_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  bpm_pkg::wave_t wave_in,
	output bpm_pkg::wave_t wave_out
);
	import bpm_pkg::*;

	logic              entry_valid_q;
	logic [ADDR_W-1:0] entry_addr_q;
	logic              wave_valid_q;
	wave_t             wave_q;
	wave_t             wave_nxt;
	logic              addr_eq;
	logic              claim_insert;
	logic              claim_remove;
	logic              check_hit;
	logic              step;

	assign step         = advance && wave_in.valid;
	assign addr_eq      = entry_valid_q && (entry_addr_q == wave_in.addr);
	assign claim_insert = (wave_in.op == OP_INSERT) && !wave_in.hit && !entry_valid_q;
	assign claim_remove = (wave_in.op == OP_REMOVE) && !wave_in.hit && addr_eq;
	assign check_hit    = (wave_in.op == OP_CHECK) && addr_eq;

	// slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= 1'b0;
		end else if (step && claim_insert) begin
			entry_valid_q <= 1'b1;
		end else if (step && claim_remove) begin
			entry_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && claim_insert) begin
			entry_addr_q <= wave_in.addr;
		end
	end

	// hand the wave to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_valid_q <= 1'b0;
		end else if (advance) begin
			wave_valid_q <= wave_in.valid;
		end
	end

	always_comb begin
		wave_nxt     = wave_in;
		wave_nxt.hit = wave_in.hit | claim_insert | claim_remove | check_hit;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			wave_q <= wave_nxt;
		end
	end

	always_comb begin
		wave_out       = wave_q;
		wave_out.valid = wave_valid_q;
	end

endmodule

// File: design/breakpoint_match_unit_core.sv
// Instruction address breakpoint table. Every transaction on the input
// channel is either an instruction check (kind 0) or a debugger memory
// write (kind 1), and each gives exactly one result transaction. The table
// is a row of NUM_BREAKPOINTS cells, one slot per cell; a transaction
// travels down the row one cell per cycle while the row is not held, and
// its result is registered after the last cell. Transactions enter back
// to back, one per cycle while the row moves, and stay in order: a later
// one always reaches a cell after the earlier one has updated it. The whole
// row holds when the result register is full and not taken. All slots are
// empty after reset; no clearing pass is needed. single_step sits at byte
// address 0 of the configuration port.
module breakpoint_match_unit_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// input channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            kind,
	input  logic [bpm_pkg::ADDR_W-1:0]      address,
	input  logic [bpm_pkg::LEN_W-1:0]       length,
	input  logic [bpm_pkg::BYTE_W-1:0]      first_byte,
	input  logic                            host_break_pending,
	// result channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      stop_reason,
	output logic [1:0]                      write_action,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bpm_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [bpm_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [bpm_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import bpm_pkg::*;

	logic              advance;
	logic              accept;
	logic              single_step_q;
	logic [POLL_W-1:0] poll_count_q;
	logic [POLL_W-1:0] poll_inc;
	logic              poll_wrap;
	logic [1:0]        last_reason_q;
	logic              out_valid_q;
	logic [1:0]        stop_reason_q;
	logic [1:0]        write_action_q;
	logic [1:0]        entry_op;
	logic [1:0]        entry_reason;
	logic [1:0]        exit_reason;
	logic [1:0]        exit_action;
	wave_t             wave [NUM_BREAKPOINTS+1];

	// the whole row moves unless a result is stuck in the output register
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = advance;
	assign accept   = in_valid && advance;

	// configuration register, always ready
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_step_q <= 1'b0;
		end else if (psel && penable && pwrite && (paddr == REG_SINGLE_STEP)) begin
			single_step_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == REG_SINGLE_STEP) begin
			prdata[0] = single_step_q;
		end
	end

	// host poll: counter wraps at POLL_INTERVAL, the wrapping check samples
	assign poll_inc  = poll_count_q + POLL_W'(1);
	assign poll_wrap = ({1'b0, poll_inc} >= (POLL_W+1)'(POLL_INTERVAL));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_count_q <= '0;
		end else if (accept && !kind) begin
			poll_count_q <= poll_wrap ? '0 : poll_inc;
		end
	end

	// decode the transaction at the head of the row
	always_comb begin
		if (!kind) begin
			entry_op = OP_CHECK;
		end else if (length == ONE_BYTE && first_byte == INSERT_BYTE) begin
			entry_op = OP_INSERT;
		end else if (length == ONE_BYTE) begin
			entry_op = OP_REMOVE;
		end else begin
			entry_op = OP_FORWARD;
		end
	end

	// user break and trace outrank a table match, so settle them here
	always_comb begin
		if (poll_wrap && host_break_pending) begin
			entry_reason = REASON_USER;
		end else if (single_step_q) begin
			entry_reason = REASON_TRACE;
		end else begin
			entry_reason = REASON_NONE;
		end
	end

	always_comb begin
		wave[0].valid      = in_valid;
		wave[0].op         = entry_op;
		wave[0].addr       = address;
		wave[0].pre_reason = entry_reason;
		wave[0].hit        = 1'b0;
	end

	// one cell per slot; hit marks a match, a claimed free slot or a freed slot
	for (genvar i = 0; i < NUM_BREAKPOINTS; i++) begin : g_cell
		bpm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.wave_in  (wave[i]),
			.wave_out (wave[i+1])
		);
	end

	// final outcome once the wave has passed every slot
	always_comb begin
		if (wave[NUM_BREAKPOINTS].pre_reason != REASON_NONE) begin
			exit_reason = wave[NUM_BREAKPOINTS].pre_reason;
		end else if (wave[NUM_BREAKPOINTS].hit) begin
			exit_reason = REASON_BREAKPOINT;
		end else begin
			exit_reason = REASON_NONE;
		end
	end

	always_comb begin
		case (wave[NUM_BREAKPOINTS].op)
			OP_CHECK:   exit_action = ACT_INSERTED;
			OP_INSERT:  exit_action = wave[NUM_BREAKPOINTS].hit ? ACT_INSERTED : ACT_FULL;
			OP_REMOVE:  exit_action = wave[NUM_BREAKPOINTS].hit ? ACT_REMOVED : ACT_FORWARD;
			default:    exit_action = ACT_FORWARD;
		endcase
	end

	// result register and remembered stop reason
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			last_reason_q <= REASON_NONE;
		end else if (advance) begin
			out_valid_q <= wave[NUM_BREAKPOINTS].valid;
			if (wave[NUM_BREAKPOINTS].valid && wave[NUM_BREAKPOINTS].op == OP_CHECK) begin
				last_reason_q <= exit_reason;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && wave[NUM_BREAKPOINTS].valid) begin
			stop_reason_q  <= (wave[NUM_BREAKPOINTS].op == OP_CHECK) ? exit_reason
			                                                         : last_reason_q;
			write_action_q <= exit_action;
		end
	end

	assign out_valid    = out_valid_q;
	assign stop_reason  = stop_reason_q;
	assign write_action = write_action_q;

endmodule
